// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the branch unit top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked assertion, disabled while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("branch unit assertion failed");
// Clocked assertion that is also checked during reset.
`define ASSERT_CLK_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("branch unit reset assertion failed");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_CLK_ALWAYS(label, clk, prop)
`endif
`endif

// ===== hw/rtl/btcu_pkg.sv =====
// Types and constants shared by the branch target and condition unit.
`timescale 1ns / 1ps
package btcu_pkg;

    // Stream widths.
    localparam int IN_TDATA_W  = 112;
    localparam int IN_TUSER_W  = 3;
    localparam int OUT_TDATA_W = 72;

    // Branch kinds.
    localparam logic [2:0] FUNC_BCOND       = 3'd0;
    localparam logic [2:0] FUNC_JMP_REG     = 3'd1;
    localparam logic [2:0] FUNC_JR_DISP22   = 3'd2;
    localparam logic [2:0] FUNC_JMP_DISP32  = 3'd3;
    localparam logic [2:0] FUNC_JARL_DISP32 = 3'd4;
    localparam logic [2:0] FUNC_JR_DISP32   = 3'd5;

    // Condition codes of the conditional branch.
    localparam logic [3:0] CC_V  = 4'h0;
    localparam logic [3:0] CC_C  = 4'h1;
    localparam logic [3:0] CC_Z  = 4'h2;
    localparam logic [3:0] CC_NH = 4'h3;
    localparam logic [3:0] CC_N  = 4'h4;
    localparam logic [3:0] CC_T  = 4'h5;
    localparam logic [3:0] CC_LT = 4'h6;
    localparam logic [3:0] CC_LE = 4'h7;
    localparam logic [3:0] CC_NV = 4'h8;
    localparam logic [3:0] CC_NC = 4'h9;
    localparam logic [3:0] CC_NZ = 4'hA;
    localparam logic [3:0] CC_H  = 4'hB;
    localparam logic [3:0] CC_P  = 4'hC;
    localparam logic [3:0] CC_SA = 4'hD;
    localparam logic [3:0] CC_GE = 4'hE;
    localparam logic [3:0] CC_GT = 4'hF;

    // Return address offsets.
    localparam logic [31:0] PC_STEP_BCOND  = 32'd2;
    localparam logic [31:0] PC_LINK_DISP22 = 32'd4;
    localparam logic [31:0] PC_LINK_DISP32 = 32'd6;

    typedef struct packed {
        logic sign;
        logic overflow;
        logic zero;
        logic carry;
        logic saturated;
    } t_flags;

    typedef struct packed {
        logic [2:0]  func;
        logic [31:0] cur_pc;
        logic [3:0]  cond_code;
        logic [31:0] disp_raw;
        logic [4:0]  reg_index;
        logic [31:0] reg_value;
        t_flags      flags;
    } t_branch_item;

    typedef struct packed {
        logic [31:0] next_pc;
        logic        taken;
        logic        link_write;
        logic [4:0]  link_index;
        logic [31:0] link_value;
    } t_branch_result;

endpackage

// ===== hw/rtl/btcu_in_stage.sv =====
// Input register stage: unpacks the slave stream and holds one item.
`timescale 1ns / 1ps
module btcu_in_stage
    import btcu_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [IN_TDATA_W-1:0] i_tdata,
    input  logic [IN_TUSER_W-1:0] i_tuser,
    output logic                  o_valid,
    input  logic                  i_ready,
    output t_branch_item          o_item
);

    logic         r_valid;
    t_branch_item r_item;
    t_branch_item n_item;

    // The stage takes an item when empty or when its item moves on.
    assign o_ready = !r_valid || i_ready;

    // Unpack the stream fields.
    always_comb begin
        n_item.func            = i_tuser[2:0];
        n_item.cur_pc          = i_tdata[31:0];
        n_item.cond_code       = i_tdata[35:32];
        n_item.disp_raw        = i_tdata[67:36];
        n_item.reg_index       = i_tdata[72:68];
        n_item.reg_value       = i_tdata[104:73];
        n_item.flags.sign      = i_tdata[105];
        n_item.flags.overflow  = i_tdata[106];
        n_item.flags.zero      = i_tdata[107];
        n_item.flags.carry     = i_tdata[108];
        n_item.flags.saturated = i_tdata[109];
    end

    // Valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Payload register.
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ===== hw/rtl/btcu_cond.sv =====
// Branch condition evaluation from the processor status flags.
`timescale 1ns / 1ps
module btcu_cond
    import btcu_pkg::*;
(
    input  logic [3:0] i_cond_code,
    input  t_flags     i_flags,
    output logic       o_cond_true
);

    logic lt;

    // Signed less-than is sign differing from overflow.
    assign lt = i_flags.sign ^ i_flags.overflow;

    always_comb begin
        case (i_cond_code)
            CC_V:    o_cond_true = i_flags.overflow;
            CC_C:    o_cond_true = i_flags.carry;
            CC_Z:    o_cond_true = i_flags.zero;
            CC_NH:   o_cond_true = i_flags.carry || i_flags.zero;
            CC_N:    o_cond_true = i_flags.sign;
            CC_T:    o_cond_true = 1'b1;
            CC_LT:   o_cond_true = lt;
            CC_LE:   o_cond_true = lt || i_flags.zero;
            CC_NV:   o_cond_true = !i_flags.overflow;
            CC_NC:   o_cond_true = !i_flags.carry;
            CC_NZ:   o_cond_true = !i_flags.zero;
            CC_H:    o_cond_true = !(i_flags.carry || i_flags.zero);
            CC_P:    o_cond_true = !i_flags.sign;
            CC_SA:   o_cond_true = i_flags.saturated;
            CC_GE:   o_cond_true = !lt;
            CC_GT:   o_cond_true = !(lt || i_flags.zero);
            default: o_cond_true = 1'b0;
        endcase
    end

endmodule

// ===== hw/rtl/btcu_resolve_stage.sv =====
// Target and link resolution with the result register on the master side.
`timescale 1ns / 1ps
module btcu_resolve_stage
    import btcu_pkg::*;
#(
    parameter int unsigned REG_COUNT = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  t_branch_item           i_item,
    input  logic                   i_cond_true,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [OUT_TDATA_W-1:0] o_tdata
);

    logic           r_valid;
    t_branch_result r_result;
    t_branch_result n_result;
    logic           base_ok;
    logic           link_ok;
    logic [31:0]    disp9;
    logic [31:0]    disp22;

    assign o_ready = !r_valid || i_ready;

    // Register range checks and sign-extended short displacements.
    assign base_ok = 32'(i_item.reg_index) < REG_COUNT;
    assign link_ok = base_ok && (i_item.reg_index != 5'd0);
    assign disp9   = {{23{i_item.disp_raw[7]}}, i_item.disp_raw[7:0], 1'b0};
    assign disp22  = {{10{i_item.disp_raw[21]}}, i_item.disp_raw[21:0]};

    // Next pc, taken mark and link write by branch kind.
    always_comb begin
        n_result.next_pc    = i_item.cur_pc;
        n_result.taken      = 1'b0;
        n_result.link_write = 1'b0;
        n_result.link_index = 5'd0;
        n_result.link_value = 32'd0;
        case (i_item.func)
            FUNC_BCOND: begin
                if (i_cond_true) begin
                    n_result.next_pc = i_item.cur_pc + disp9;
                    n_result.taken   = 1'b1;
                end else begin
                    n_result.next_pc = i_item.cur_pc + PC_STEP_BCOND;
                end
            end
            FUNC_JMP_REG: begin
                if (base_ok) begin
                    n_result.next_pc = i_item.reg_value;
                    n_result.taken   = 1'b1;
                end
            end
            FUNC_JR_DISP22: begin
                n_result.next_pc = i_item.cur_pc + disp22;
                n_result.taken   = 1'b1;
                if (link_ok) begin
                    n_result.link_write = 1'b1;
                    n_result.link_index = i_item.reg_index;
                    n_result.link_value = i_item.cur_pc + PC_LINK_DISP22;
                end
            end
            FUNC_JMP_DISP32: begin
                if (base_ok) begin
                    n_result.next_pc = i_item.reg_value + i_item.disp_raw;
                    n_result.taken   = 1'b1;
                end
            end
            FUNC_JARL_DISP32: begin
                n_result.next_pc = i_item.cur_pc + i_item.disp_raw;
                n_result.taken   = 1'b1;
                if (link_ok) begin
                    n_result.link_write = 1'b1;
                    n_result.link_index = i_item.reg_index;
                    n_result.link_value = i_item.cur_pc + PC_LINK_DISP32;
                end
            end
            FUNC_JR_DISP32: begin
                n_result.next_pc = i_item.cur_pc + i_item.disp_raw;
                n_result.taken   = 1'b1;
            end
            default: begin
                n_result.taken = 1'b0;
            end
        endcase
    end

    // Result valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Result payload register.
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_result <= n_result;
        end
    end

    // Pack the master stream fields.
    assign o_valid = r_valid;
    assign o_tdata = {1'b0, r_result.link_value, r_result.link_index,
                      r_result.link_write, r_result.taken, r_result.next_pc};

endmodule

// ===== hw/rtl/branch_target_and_condition_unit.sv =====
// Top level of the branch target and condition unit.
`timescale 1ns / 1ps
`include "assert_macros.svh"
//
//  Channel   Direction  Payload
//  s_axis    in         branch item: kind in tuser, operands and flags in tdata
//  m_axis    out        next pc, taken mark and link register write in tdata
//
//  One item per cycle is sustained while m_axis is ready; each item passes
//  through the input register and then the result register.
//  Reset (i_rst_n low at a clock edge) empties both registers.
//  A stall on m_axis holds the result; the input register still takes an
//  item while the result register waits, then ready drops until it drains.
module branch_target_and_condition_unit
    import btcu_pkg::*;
#(
    parameter int unsigned REG_COUNT = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // From bit 0: cur_pc[31:0], cond_code[35:32], disp_raw[67:36],
    // reg_index[72:68], reg_value[104:73], flag_sign[105],
    // flag_overflow[106], flag_zero[107], flag_carry[108],
    // flag_saturated[109], zero fill[111:110].
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // From bit 0: func[2:0].
    input  logic [IN_TUSER_W-1:0]  s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // From bit 0: next_pc[31:0], taken[32], link_write[33],
    // link_index[38:34], link_value[70:39], zero fill[71].
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    logic         item_valid;
    logic         item_ready;
    t_branch_item item;
    logic         cond_true;

    btcu_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_tdata (s_axis_tdata),
        .i_tuser (s_axis_tuser),
        .o_valid (item_valid),
        .i_ready (item_ready),
        .o_item  (item)
    );

    btcu_cond u_cond (
        .i_cond_code (item.cond_code),
        .i_flags     (item.flags),
        .o_cond_true (cond_true)
    );

    btcu_resolve_stage #(
        .REG_COUNT (REG_COUNT)
    ) u_resolve_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (item_valid),
        .o_ready     (item_ready),
        .i_item      (item),
        .i_cond_true (cond_true),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_tdata     (m_axis_tdata)
    );

    // A link write never targets register zero.
    `ASSERT_CLK(a_no_link_r0, i_clk, i_rst_n, (m_axis_tvalid && m_axis_tdata[33]) |-> (m_axis_tdata[38:34] != 5'd0))
    // Every link write comes with a taken branch.
    `ASSERT_CLK(a_link_taken, i_clk, i_rst_n, (m_axis_tvalid && m_axis_tdata[33]) |-> m_axis_tdata[32])
    // Without a link write the link fields read as zero.
    `ASSERT_CLK(a_link_idle_zero, i_clk, i_rst_n, (m_axis_tvalid && !m_axis_tdata[33]) |-> ((m_axis_tdata[38:34] == 5'd0) && (m_axis_tdata[70:39] == 32'd0)))
    // Reset empties the result register.
    `ASSERT_CLK_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !m_axis_tvalid)

endmodule
